>>> hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and byte-level functions for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned RND_W      = 4;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  // register indexes on the configuration port
  localparam logic [0:0] REG_KEY_UPPER = 1'b0;
  localparam logic [0:0] REG_KEY_LOWER = 1'b1;

  // controller commands to the datapath
  typedef struct packed {
    logic load;   // take a new word, apply the initial key add
    logic round;  // run one cipher round
    logic last;   // this round omits MixColumns
  } aes_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // byte n of a 128-bit word, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int unsigned n);
    return w[127 - 8*n -: 8];
  endfunction

endpackage

>>> hdl/aes_word_if.sv
// ----------------------------------------------------------------------------
// AES word channel
// Valid/ready channel carrying one 128-bit block and its last-block flag.
// ----------------------------------------------------------------------------
interface aes_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_upper;
  logic [63:0] data_lower;
  logic        last;

  modport source (output valid, output data_upper, output data_lower, output last,
                  input ready);
  modport sink   (input valid, input data_upper, input data_lower, input last,
                  output ready);
endinterface

>>> hdl/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt top level
// ECB encryption of 128-bit words under a key set over the APB-style port.
// ----------------------------------------------------------------------------
// One word at a time: a word is taken in IDLE (initial key add), then the
// ten rounds run one after another in RUN through a single round unit whose
// round key is derived alongside; the result is then offered in DONE, and a
// new word is taken only after the result is taken. The key registers sit
// at byte addresses 0 (upper) and 8 (lower), 64 bits each, and reset to
// zero; write them only while idle. The last-block flag passes through
// with its word.
module aes128_block_encrypt_top (
  input  logic        clk,
  input  logic        rst_n,
  aes_word_if.sink    in_if,
  aes_word_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import aes_pkg::*;

  logic [63:0]  key_upper_r, key_lower_r;
  logic         wr_en;
  aes_cmd_t     cmd;
  logic [127:0] cipher;
  logic         last_out;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // write the key registers; drop writes to unknown addresses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (wr_en && cfg_paddr[2:0] == 3'd0) begin
      if (cfg_paddr[3] == REG_KEY_UPPER) key_upper_r <= cfg_pwdata;
      else                               key_lower_r <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2:0] == 3'd0) begin
      cfg_prdata = (cfg_paddr[3] == REG_KEY_LOWER) ? key_lower_r : key_upper_r;
    end
  end

  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .cmd      (cmd)
  );

  aes_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .key     ({key_upper_r, key_lower_r}),
    .plain   ({in_if.data_upper, in_if.data_lower}),
    .last_in (in_if.last),
    .cipher  (cipher),
    .last_out(last_out)
  );

  assign out_if.data_upper = cipher[127:64];
  assign out_if.data_lower = cipher[63:0];
  assign out_if.last       = last_out;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(cipher))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid))
    else $error("input open while result pending");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("accepted word did not start work");
`endif
endmodule

>>> hdl/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES controller
// Sequences load, ten rounds and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aes_pkg::aes_cmd_t cmd
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] rnd_r, rnd_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          rnd_nxt   = RND_W'(1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.round = 1'b1;
        cmd.last  = (rnd_r == RND_W'(NUM_ROUNDS));
        rnd_nxt   = rnd_r + RND_W'(1);
        if (cmd.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

`ifndef SYNTHESIS
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> (rnd_r >= RND_W'(1) && rnd_r <= RND_W'(NUM_ROUNDS)))
    else $error("round counter out of range");
  a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last |=> state_r == ST_DONE)
    else $error("last round did not finish");
  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_RUN && rnd_r == RND_W'(1))
    else $error("load did not start round one");
`endif
endmodule

>>> hdl/aes_dp.sv
// ----------------------------------------------------------------------------
// AES datapath
// State register, one round unit and an on-the-fly round key schedule.
// ----------------------------------------------------------------------------
module aes_dp (
  input  logic              clk,
  input  aes_pkg::aes_cmd_t cmd,
  input  logic [127:0]      key,
  input  logic [127:0]      plain,
  input  logic              last_in,
  output logic [127:0]      cipher,
  output logic              last_out
);
  import aes_pkg::*;

  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic         last_r;
  logic [127:0] sr, mc, nk;
  logic [31:0]  tw;

  // next round key from the current one
  always_comb begin
    tw = {SBOX[rk_r[23:16]], SBOX[rk_r[15:8]], SBOX[rk_r[7:0]], SBOX[rk_r[31:24]]}
         ^ {rcon_r, 24'h0};
    nk[127:96] = rk_r[127:96] ^ tw;
    nk[95:64]  = rk_r[95:64]  ^ nk[127:96];
    nk[63:32]  = rk_r[63:32]  ^ nk[95:64];
    nk[31:0]   = rk_r[31:0]   ^ nk[63:32];
  end

  // SubBytes and ShiftRows, then MixColumns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8*(c*4+r) -: 8] = SBOX[get_byte(st_r, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = get_byte(sr, c*4);
      a1 = get_byte(sr, c*4+1);
      a2 = get_byte(sr, c*4+2);
      a3 = get_byte(sr, c*4+3);
      mc[127 - 32*c -: 32] = {
        gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3,
        a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3,
        a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3,
        gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3)};
    end
  end

  always_comb begin
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rcon_nxt = rcon_r;
    if (cmd.load) begin
      st_nxt   = plain ^ key;
      rk_nxt   = key;
      rcon_nxt = RCON_INIT;
    end else if (cmd.round) begin
      st_nxt   = (cmd.last ? sr : mc) ^ nk;
      rk_nxt   = nk;
      rcon_nxt = gf_double(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    rk_r   <= rk_nxt;
    rcon_r <= rcon_nxt;
    if (cmd.load) last_r <= last_in;
  end

  assign cipher   = st_r;
  assign last_out = last_r;
endmodule

>>> tb/sv/aes128_block_encrypt_top_tb.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt testbench
// Drives plaintext words and key writes into the encrypt core, computes each
// ciphertext with a behavioural AES-128 model and compares every result word.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_top_tb;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] upper;
    logic [63:0] lower;
    logic        last;
  } aes_word_t;

  typedef logic [7:0] state_t [16];

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  aes_word_if in_if ();
  aes_word_if out_if ();

  aes128_block_encrypt_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if.sink),
    .out_if     (out_if.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Key copy held by the predictor, updated with every register write.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;

  aes_word_t cipher_q [$];   // ciphertext words still owed by the core
  int        n_errors;
  int        n_words_sent;
  int        n_words_seen;
  int        n_last_seen;
  bit        hold_off;       // ask the receiver to stall for a long stretch

  // Clock: period 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // AES-128 predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic aes_word_t encrypt_word(input aes_word_t pt);
    logic [7:0] rkey [176];
    logic [7:0] t [4];
    logic [7:0] tmp;
    logic [7:0] rc;
    state_t     st;
    state_t     old;
    logic [7:0] a0, a1, a2, a3;
    aes_word_t  ct;
    rc = 8'h01;
    for (int n = 0; n < 8; n++) begin
      rkey[n]     = key_hi_q[63 - 8*n -: 8];
      rkey[8 + n] = key_lo_q[63 - 8*n -: 8];
      st[n]       = pt.upper[63 - 8*n -: 8];
      st[8 + n]   = pt.lower[63 - 8*n -: 8];
    end
    // Expand the schedule: RotWord, SubWord and Rcon on every fourth word.
    for (int w = 4; w < 44; w++) begin
      for (int k = 0; k < 4; k++) t[k] = rkey[(w - 1)*4 + k];
      if (w % 4 == 0) begin
        tmp  = t[0];
        t[0] = SBOX[t[1]] ^ rc;
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[tmp];
        rc   = xtime(rc);
      end
      for (int k = 0; k < 4; k++) rkey[w*4 + k] = rkey[(w - 4)*4 + k] ^ t[k];
    end
    for (int k = 0; k < 16; k++) st[k] ^= rkey[k];
    for (int r = 1; r <= 10; r++) begin
      old = st;
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) st[c*4 + w] = SBOX[old[((c + w) % 4)*4 + w]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4 + 1]; a2 = st[c*4 + 2]; a3 = st[c*4 + 3];
          st[c*4]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
          st[c*4 + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
          st[c*4 + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
          st[c*4 + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
      end
      for (int k = 0; k < 16; k++) st[k] ^= rkey[r*16 + k];
    end
    for (int n = 0; n < 8; n++) begin
      ct.upper[63 - 8*n -: 8] = st[n];
      ct.lower[63 - 8*n -: 8] = st[8 + n];
    end
    ct.last = pt.last;
    return ct;
  endfunction

  // --------------------------------------------------------------------------
  // Shared tasks
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    $display("MISMATCH word %0d %s: got %h want %h", n_words_seen, what, got, want);
  endtask

  // Write one key register over the APB-style port: setup then access.
  task automatic write_key_reg(input logic [0:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_KEY_UPPER) key_hi_q = value;
    else key_lo_q = value;
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    write_key_reg(REG_KEY_UPPER, hi);
    write_key_reg(REG_KEY_LOWER, lo);
  endtask

  // Offer one plaintext word after a random gap (none when eager); hold valid until taken.
  // Valid stays high past the accepting edge until the next call or a drain
  // moves it at the following negedge; the core is busy by then.
  task automatic send_word(input logic [63:0] hi, input logic [63:0] lo,
                           input logic last, input bit eager);
    aes_word_t pt;
    int        gap;
    gap = eager ? 0 : $urandom_range(0, 13);
    pt = '{upper: hi, lower: lo, last: last};
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_upper <= hi;
    in_if.data_lower <= lo;
    in_if.last       <= last;
    do @(posedge clk); while (!in_if.ready);
    cipher_q.push_back(encrypt_word(pt));
    n_words_sent++;
  endtask

  // Drop valid, wait for every owed word, then let the core settle.
  task automatic drain;
    int guard;
    guard = 0;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (cipher_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // Random plaintext, often with walking or saturated halves.
  task automatic send_random(input bit eager);
    logic [63:0] hi, lo;
    case ($urandom_range(0, 7))
      0:       begin hi = 64'h1 << $urandom_range(0, 63); lo = rand64(); end
      1:       begin hi = rand64(); lo = ~(64'h1 << $urandom_range(0, 63)); end
      2:       begin hi = '1; lo = '0; end
      default: begin hi = rand64(); lo = rand64(); end
    endcase
    send_word(hi, lo, $urandom_range(0, 3) == 0, eager);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, with the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < 300; c++) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Checker: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    aes_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.data_upper, 64'd0);
      end else begin
        want = cipher_q.pop_front();
        if (out_if.data_upper !== want.upper)
          report_mismatch("cipher_upper", out_if.data_upper, want.upper);
        if (out_if.data_lower !== want.lower)
          report_mismatch("cipher_lower", out_if.data_lower, want.lower);
        if (out_if.last !== want.last)
          report_mismatch("final_out", {63'd0, out_if.last}, {63'd0, want.last});
      end
      n_words_seen++;
      if (out_if.last === 1'b1) n_last_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset key of zero, the FIPS-197 vector and saturated keys and data.
  task automatic test_directed;
    send_word('0, '0, 1'b0, 1'b0);
    send_word('1, '1, 1'b1, 1'b0);
    drain();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_word(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
    send_word(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0, 1'b0);
    drain();
    load_key('1, '1);
    send_word('0, '0, 1'b0, 1'b1);
    send_word('1, '1, 1'b1, 1'b1);
    send_word(64'h8000000000000000, 64'h0000000000000001, 1'b0, 1'b0);
    drain();
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_word(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1, 1'b0);
    send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b0);
    drain();
    // Only the upper half changes: the lower key must persist.
    write_key_reg(REG_KEY_UPPER, '0);
    send_word(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0);
    drain();
  endtask

  // Messages of random length under a series of keys, mostly random.
  task automatic test_random_messages;
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) load_key('0, '1);
      else if (ph == 1) load_key('1, '0);
      else load_key(rand64(), rand64());
      repeat (140) send_random($urandom_range(0, 4) == 0);
      drain();
    end
  endtask

  // Stall the receiver for a long stretch while words keep arriving.
  task automatic test_backpressure;
    load_key(rand64(), rand64());
    hold_off = 1'b1;
    repeat (40) send_random(1'b1);
    drain();
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_if.valid      = 1'b0;
    in_if.data_upper = '0;
    in_if.data_lower = '0;
    in_if.last       = 1'b0;
    key_hi_q = '0;
    key_lo_q = '0;
    hold_off = 1'b0;
    n_errors = 0;
    n_words_sent = 0;
    n_words_seen = 0;
    n_last_seen  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random_messages();

    if (cipher_q.size() != 0) begin
      report_mismatch("result words never arrived", 64'(cipher_q.size()), 64'd0);
    end
    $display("Encrypted %0d words under 15+ keys, %0d flagged as message end.",
             n_words_seen, n_last_seen);
    $display("Included a long receiver stall with a continuous sender.");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: generous bound on the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
hdl/aes_pkg.sv
hdl/aes_word_if.sv
hdl/aes_ctrl.sv
hdl/aes_dp.sv
hdl/aes128_block_encrypt_top.sv
tb/sv/aes128_block_encrypt_top_tb.sv
